FILE: src/mme_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the matrix multiply engine.
// No dependencies; every other file of the block but mme_ram imports this package.
package mme_pkg;

  localparam int IDX_W     = 3;
  localparam int DIM_W     = 4;
  localparam int OUT_W     = 35;
  localparam int ACT_W     = 2;
  localparam int CFG_IDX_W = 8;

  localparam logic [ACT_W-1:0] ACT_LOAD_A  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD_B  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 8'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef struct packed {
    logic [DIM_W-1:0] nr;
    logic [DIM_W-1:0] nk;
    logic [DIM_W-1:0] nc;
  } dims_t;

endpackage

FILE: src/mme_in_if.sv
`timescale 1ns / 1ps
// Input channel of the matrix multiply engine: load and compute transactions.
// Depends on mme_pkg.
interface mme_in_if #(
  parameter int ELEM_BITS = 16
);
  import mme_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [ACT_W-1:0]            action;
  logic [IDX_W-1:0]            elem_row;
  logic [IDX_W-1:0]            elem_col;
  logic signed [ELEM_BITS-1:0] elem_value;

  modport source (output valid, action, elem_row, elem_col, elem_value, input ready);
  modport sink (input valid, action, elem_row, elem_col, elem_value, output ready);
endinterface

FILE: src/mme_out_if.sv
`timescale 1ns / 1ps
// Result channel of the matrix multiply engine: one element of C per transaction.
// Depends on mme_pkg.
interface mme_out_if;
  import mme_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic signed [OUT_W-1:0] out_value;
  logic                    last;

  modport source (output valid, out_row, out_col, out_value, last, input ready);
  modport sink (input valid, out_row, out_col, out_value, last, output ready);
endinterface

FILE: src/mme_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel of the matrix multiply engine.
// Depends on mme_pkg.
interface mme_cfg_if;
  import mme_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] idx;
  logic [DIM_W-1:0]     wdata;

  modport source (output valid, idx, wdata, input ready);
  modport sink (input valid, idx, wdata, output ready);
endinterface

FILE: src/mme_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

FILE: src/mme_mac_seq.sv
`timescale 1ns / 1ps
// Compute sequencer: walks row, column and inner index, reads both stores,
// multiplies, accumulates and holds each finished element in an output register.
// Depends on mme_pkg, mme_out_if.
module mme_mac_seq #(
  parameter int MAX_DIM   = 8,
  parameter int ELEM_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  mme_pkg::dims_t                         dims,
  output logic                                   busy,
  output logic                                   ren,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     a_addr,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     b_addr,
  input  logic [ELEM_BITS-1:0]                   a_rdata,
  input  logic [ELEM_BITS-1:0]                   b_rdata,
  mme_out_if.source                              out_ch
);
  import mme_pkg::*;

  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
  localparam int PROD_W = 2 * ELEM_BITS;

  typedef struct packed {
    logic             first;
    logic             lastk;
    logic             last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] col_r, col_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  logic             s2_valid_r, s2_valid_nxt;
  logic             out_valid_r, out_valid_nxt;
  tag_t             s1_tag_r, s2_tag_r, issue_tag;
  logic signed [OUT_W-1:0]  s2_prod_r, acc_r, acc_sum, out_value_r;
  logic signed [PROD_W-1:0] prod_full;
  logic signed [ELEM_BITS-1:0] a_s, b_s;
  logic [IDX_W-1:0] out_row_r, out_col_r;
  logic             out_last_r;
  logic             en, last_k, last_c, last_r;

  assign en     = !out_valid_r || out_ch.ready;
  assign last_k = ({1'b0, k_r} == dims.nk - DIM_W'(1));
  assign last_c = ({1'b0, col_r} == dims.nc - DIM_W'(1));
  assign last_r = ({1'b0, row_r} == dims.nr - DIM_W'(1));

  assign issue_tag = '{first: (k_r == '0), lastk: last_k, last: last_k && last_c && last_r,
                       row: row_r, col: col_r};

  assign ren    = busy_r && en;
  assign a_addr = ADDR_W'(row_r) * ADDR_W'(MAX_DIM) + ADDR_W'(k_r);
  assign b_addr = ADDR_W'(k_r) * ADDR_W'(MAX_DIM) + ADDR_W'(col_r);
  assign busy   = busy_r;

  always_comb begin
    busy_nxt = busy_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    k_nxt    = k_r;
    if (start) begin
      busy_nxt = 1'b1;
      row_nxt  = '0;
      col_nxt  = '0;
      k_nxt    = '0;
    end else if (busy_r && en) begin
      if (last_k) begin
        k_nxt = '0;
        if (last_c) begin
          col_nxt = '0;
          if (last_r) begin
            busy_nxt = 1'b0;
          end else begin
            row_nxt = row_r + IDX_W'(1);
          end
        end else begin
          col_nxt = col_r + IDX_W'(1);
        end
      end else begin
        k_nxt = k_r + IDX_W'(1);
      end
    end
  end

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s2_valid_nxt  = s2_valid_r;
    out_valid_nxt = out_valid_r;
    if (en) begin
      s1_valid_nxt  = busy_r;
      s2_valid_nxt  = s1_valid_r;
      out_valid_nxt = s2_valid_r && s2_tag_r.lastk;
    end
  end

  assign a_s       = $signed(a_rdata);
  assign b_s       = $signed(b_rdata);
  assign prod_full = a_s * b_s;
  assign acc_sum   = (s2_tag_r.first ? '0 : acc_r) + s2_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      k_r         <= '0;
    end else begin
      busy_r      <= busy_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tag_r  <= issue_tag;
      s2_tag_r  <= s1_tag_r;
      s2_prod_r <= OUT_W'(prod_full);
      if (s2_valid_r) begin
        acc_r <= acc_sum;
        if (s2_tag_r.lastk) begin
          out_value_r <= acc_sum;
          out_row_r   <= s2_tag_r.row;
          out_col_r   <= s2_tag_r.col;
          out_last_r  <= s2_tag_r.last;
        end
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_row   = out_row_r;
  assign out_ch.out_col   = out_col_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.last      = out_last_r;
endmodule

FILE: src/matrix_multiply_engine.sv
`timescale 1ns / 1ps
// Matrix multiply engine top level: configuration registers, load decode,
// the A and B element stores and the compute sequencer.
// Depends on mme_pkg, mme_in_if, mme_out_if, mme_cfg_if, mme_ram, mme_mac_seq.
// Loads are accepted while no compute runs and may follow back to back.
// A compute transaction holds the input for rows_a*cols_b*inner_dim
// multiply-accumulates, dimensions clamped to 1..MAX_DIM, one per cycle through
// the store read ports while the output is not stalled.
// Reset is synchronous: dimensions return to 8, stored elements are undefined.
module matrix_multiply_engine #(
  parameter int MAX_DIM   = 8,
  parameter int ELEM_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  mme_in_if.sink     in_ch,
  mme_out_if.source  out_ch,
  mme_cfg_if.sink    cfg_ch
);
  import mme_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [DIM_W-1:0]     rows_a_r, inner_dim_r, cols_b_r;
  dims_t                dims;
  logic                 busy, in_acc, cfg_acc, in_range, we_a, we_b, start, ren;
  logic [ADDR_W-1:0]    waddr, a_addr, b_addr;
  logic [ELEM_BITS-1:0] a_rdata, b_rdata;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_RESET;
      inner_dim_r <= DIM_RESET;
      cols_b_r    <= DIM_RESET;
    end else if (cfg_acc) begin
      case (cfg_ch.idx)
        REG_ROWS_A:    rows_a_r    <= cfg_ch.wdata;
        REG_INNER_DIM: inner_dim_r <= cfg_ch.wdata;
        REG_COLS_B:    cols_b_r    <= cfg_ch.wdata;
        default: begin
        end
      endcase
    end
  end

  assign dims = '{nr: clamp_dim(rows_a_r), nk: clamp_dim(inner_dim_r),
                  nc: clamp_dim(cols_b_r)};

  assign in_ch.ready = !busy;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_range    = ({1'b0, in_ch.elem_row} < DIM_W'(MAX_DIM)) &&
                       ({1'b0, in_ch.elem_col} < DIM_W'(MAX_DIM));
  assign we_a        = in_acc && in_range && (in_ch.action == ACT_LOAD_A);
  assign we_b        = in_acc && in_range && (in_ch.action == ACT_LOAD_B);
  assign start       = in_acc && (in_ch.action == ACT_COMPUTE);
  assign waddr       = ADDR_W'(in_ch.elem_row) * ADDR_W'(MAX_DIM) + ADDR_W'(in_ch.elem_col);

  mme_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (in_ch.elem_value),
    .re    (ren),
    .raddr (a_addr),
    .rdata (a_rdata)
  );

  mme_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (in_ch.elem_value),
    .re    (ren),
    .raddr (b_addr),
    .rdata (b_rdata)
  );

  mme_mac_seq #(.MAX_DIM(MAX_DIM), .ELEM_BITS(ELEM_BITS)) u_mac_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .dims    (dims),
    .busy    (busy),
    .ren     (ren),
    .a_addr  (a_addr),
    .b_addr  (b_addr),
    .a_rdata (a_rdata),
    .b_rdata (b_rdata),
    .out_ch  (out_ch)
  );
endmodule
